// ===== design/swaf_pkg.sv =====
// Shared constants, types and the histogram control struct for the anagram finder.
package swaf_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int ALPHABET    = 26;
    localparam int OPCODE_W    = 2;
    localparam int LETTER_W    = 5;
    localparam int INDEX_W     = 32;
    localparam int CNT_W       = $clog2(MAX_PATTERN + 1);
    localparam int RING_W      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int SLOT_W      = CNT_W + 1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR   = 2'd0,
        OP_PATTERN = 2'd1,
        OP_TEXT    = 2'd2
    } t_opcode;

    typedef logic [LETTER_W-1:0] t_letter;
    typedef logic [CNT_W-1:0]    t_count;
    typedef logic [RING_W-1:0]   t_ring;
    typedef logic [INDEX_W-1:0]  t_index;

    typedef struct packed {
        logic    clear_all;
        logic    restart_text;
        logic    pat_inc;
        t_letter pat_letter;
        logic    win_inc;
        t_letter win_letter;
        logic    win_dec;
        t_letter dec_letter;
    } t_hist_ctl;

endpackage

// ===== design/swaf_if.sv =====
// Valid/ready channel interfaces for the input letters and the result indexes.
interface swaf_in_if import swaf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OPCODE_W-1:0] opcode;
    t_letter           letter;

    modport source (output valid, output opcode, output letter, input ready);
    modport sink   (input valid, input opcode, input letter, output ready);
endinterface

interface swaf_out_if import swaf_pkg::*; ();
    logic   valid;
    logic   ready;
    t_index start_index;

    modport source (output valid, output start_index, input ready);
    modport sink   (input valid, input start_index, output ready);
endinterface

// ===== design/swaf_hist_cell.sv =====
// One letter lane: pattern count and window count with next-value compare.
module swaf_hist_cell import swaf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_letter   i_index,
    input  t_hist_ctl i_ctl,
    output logic      o_eq
);

    t_count r_pat;
    t_count r_win;
    t_count n_pat;
    t_count n_win;
    logic   hit_pat;
    logic   hit_inc;
    logic   hit_dec;

    assign hit_pat = i_ctl.pat_inc && (i_ctl.pat_letter == i_index);
    assign hit_inc = i_ctl.win_inc && (i_ctl.win_letter == i_index);
    // A count never drops below zero.
    assign hit_dec = i_ctl.win_dec && (i_ctl.dec_letter == i_index) && (r_win != '0);

    always_comb begin
        n_pat = r_pat;
        if (i_ctl.clear_all) begin
            n_pat = '0;
        end else if (hit_pat) begin
            n_pat = r_pat + CNT_W'(1);
        end
    end

    always_comb begin
        n_win = r_win;
        if (i_ctl.clear_all || i_ctl.restart_text) begin
            n_win = '0;
        end else if (hit_inc && !hit_dec) begin
            n_win = r_win + CNT_W'(1);
        end else if (hit_dec && !hit_inc) begin
            n_win = r_win - CNT_W'(1);
        end
    end

    assign o_eq = (n_pat == n_win);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat <= '0;
            r_win <= '0;
        end else begin
            r_pat <= n_pat;
            r_win <= n_win;
        end
    end

endmodule

// ===== design/swaf_ring.sv =====
// Ring of recent text letters: one write port, one registered read with write bypass.
module swaf_ring import swaf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_wr_en,
    input  t_ring   i_wr_addr,
    input  t_letter i_wr_data,
    input  t_ring   i_rd_addr,
    output t_letter o_rd_data
);

    t_letter r_mem [MAX_PATTERN];
    t_letter r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // The read returns the letter being written when both hit the same slot.
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
            r_rd_data <= i_wr_data;
        end else begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/sliding_window_anagram_finder_top.sv =====
// Top level of the sliding-window anagram finder.
//
//  Port       Dir   Beat payload              Meaning
//  i_item     in    opcode[1:0], letter[4:0]  clear, pattern letter or text letter
//  o_result   out   start_index[31:0]         start of a window that is a permutation
//
// One beat is taken every cycle while the result register is not stalled; the beat passes
// through the input register and its result is then held in the result register.
// Throughput is set by the single histogram update and the 26-lane compare per beat.
// Reset is synchronous and clears all counts and pointers; the letter ring is not
// cleared, since an entry is only read once it has been rewritten after a restart.
// A stalled result register holds the input register, which in turn drops i_item.ready.
module sliding_window_anagram_finder_top import swaf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    swaf_in_if.sink    i_item,
    swaf_out_if.source o_result
);

    logic                r_in_valid;
    logic [OPCODE_W-1:0] r_op;
    t_letter             r_letter;

    t_ring   r_rp;
    t_count  r_len;
    t_count  r_fill;
    t_index  r_tc;
    t_ring   n_rp;
    t_count  n_len;
    t_count  n_fill;
    t_index  n_tc;

    logic    r_out_valid;
    t_index  r_start;

    logic                proc_fire;
    logic                letter_ok;
    logic                is_clear;
    logic                is_pat;
    logic                is_text;
    logic                text_dirty;
    logic                len_nz;
    logic                full;
    logic                gone_ok;
    logic                match;
    t_letter             gone;
    t_hist_ctl           ctl;
    logic [ALPHABET-1:0] eq;
    t_ring               rd_addr;
    logic [SLOT_W-1:0]   slot;
    t_index              n_start;

    // Input register.
    assign proc_fire    = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || proc_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_op     <= i_item.opcode;
            r_letter <= i_item.letter;
        end
    end

    // Decode the registered beat.
    assign letter_ok  = {1'b0, r_letter} < (LETTER_W + 1)'(ALPHABET);
    assign gone_ok    = {1'b0, gone} < (LETTER_W + 1)'(ALPHABET);
    assign is_clear   = proc_fire && (r_op == OP_CLEAR);
    assign is_pat     = proc_fire && (r_op == OP_PATTERN) && letter_ok;
    assign is_text    = proc_fire && (r_op == OP_TEXT) && letter_ok;
    assign text_dirty = (r_tc != '0) || (r_fill != '0) || (r_rp != '0);
    assign len_nz     = (r_len != '0);
    assign full       = (r_fill >= r_len);

    always_comb begin
        ctl              = '0;
        ctl.clear_all    = is_clear;
        ctl.restart_text = is_pat && text_dirty;
        ctl.pat_inc      = is_pat && (r_len < CNT_W'(MAX_PATTERN));
        ctl.pat_letter   = r_letter;
        ctl.win_inc      = is_text && len_nz;
        ctl.win_letter   = r_letter;
        ctl.win_dec      = is_text && len_nz && full && gone_ok;
        ctl.dec_letter   = gone;
    end

    for (genvar g = 0; g < ALPHABET; g++) begin : g_cell
        swaf_hist_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (LETTER_W'(g)),
            .i_ctl   (ctl),
            .o_eq    (eq[g])
        );
    end

    // Scalar state.
    always_comb begin
        n_rp   = r_rp;
        n_len  = r_len;
        n_fill = r_fill;
        n_tc   = r_tc;
        if (is_clear) begin
            n_rp   = '0;
            n_len  = '0;
            n_fill = '0;
            n_tc   = '0;
        end else if (is_pat) begin
            if (text_dirty) begin
                n_rp   = '0;
                n_fill = '0;
                n_tc   = '0;
            end
            if (r_len < CNT_W'(MAX_PATTERN)) begin
                n_len = r_len + CNT_W'(1);
            end
        end else if (is_text) begin
            if (len_nz && !full) begin
                n_fill = r_fill + CNT_W'(1);
            end
            n_rp = (r_rp == RING_W'(MAX_PATTERN - 1)) ? '0 : r_rp + RING_W'(1);
            n_tc = r_tc + INDEX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp   <= '0;
            r_len  <= '0;
            r_fill <= '0;
            r_tc   <= '0;
        end else begin
            r_rp   <= n_rp;
            r_len  <= n_len;
            r_fill <= n_fill;
            r_tc   <= n_tc;
        end
    end

    // The slot of the letter leaving the window is fetched ahead through the registered ring read,
    // from the pointer and length that the next beat will see.
    always_comb begin
        if (SLOT_W'(n_rp) >= SLOT_W'(n_len)) begin
            slot = SLOT_W'(n_rp) - SLOT_W'(n_len);
        end else begin
            slot = SLOT_W'(n_rp) + SLOT_W'(MAX_PATTERN) - SLOT_W'(n_len);
        end
    end

    assign rd_addr = slot[RING_W-1:0];

    swaf_ring u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (is_text),
        .i_wr_addr (r_rp),
        .i_wr_data (r_letter),
        .i_rd_addr (rd_addr),
        .o_rd_data (gone)
    );

    // Result register.
    assign match   = is_text && len_nz && (n_fill >= r_len) && (&eq);
    assign n_start = n_tc - INDEX_W'(r_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire) begin
            r_out_valid <= match;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire && match) begin
            r_start <= n_start;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.start_index = r_start;

    // Checks on the internal state.
    a_fill_le_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_len)
        else $error("window fill exceeds pattern length");

    a_ring_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SLOT_W'(r_rp) < SLOT_W'(MAX_PATTERN))
        else $error("ring pointer out of range");

    a_clear_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_clear |=> (r_len == '0) && (r_tc == '0) && (r_fill == '0))
        else $error("clear left state behind");

    a_result_from_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(proc_fire && (r_op == OP_TEXT)))
        else $error("result without a text beat");

endmodule

// ===== dv/tb_sliding_window_anagram_finder_top.sv =====
`timescale 1ns / 100ps
// Testbench for the sliding-window anagram finder: directed table, then random letter streams.
module tb_sliding_window_anagram_finder_top import swaf_pkg::*; ();

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam t_letter LTR_A   = 5'd0;
    localparam t_letter LTR_B   = 5'd1;
    localparam t_letter LTR_Z   = 5'd25;
    localparam t_letter LTR_OUT = 5'd26;
    localparam t_letter LTR_MAX = 5'd31;
    localparam int      N_DIRECTED = 25;
    localparam int      N_RANDOM   = 1800;

    // How a beat's result is checked: against the predictor, or against a typed value.
    typedef enum logic [1:0] {
        ROW_CHECK_MODEL = 2'd0,
        ROW_NO_HIT      = 2'd1,
        ROW_HIT         = 2'd2
    } t_row_check;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        t_letter             ltr;
        t_row_check          check;
        t_index              start;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    swaf_in_if  item_if();
    swaf_out_if result_if();

    sliding_window_anagram_finder_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Predictor state.
    t_count  pat_hist [ALPHABET];
    t_count  win_hist [ALPHABET];
    t_letter recent [MAX_PATTERN];
    t_ring   ring_ptr;
    t_count  pat_len;
    t_count  win_fill;
    t_index  text_pos;

    t_index     pending_starts [$];
    t_letter    gen_pattern [$];
    t_row_check beat_check;
    t_index     beat_start;
    int         mismatches;
    int         burst_left;
    int         beats_sent;
    logic [11:0] stall_tick;
    bit         step_hit;
    t_index     step_start;
    t_index     exp_start;

    task automatic restart_window();
        for (int i = 0; i < ALPHABET; i++) win_hist[i] = '0;
        ring_ptr = '0;
        win_fill = '0;
        text_pos = '0;
    endtask

    task automatic forget_all();
        for (int i = 0; i < ALPHABET; i++) pat_hist[i] = '0;
        pat_len = '0;
        restart_window();
    endtask

    task automatic anagram_step(input logic [OPCODE_W-1:0] op, input t_letter ltr,
                                output bit hit, output t_index start);
        int unsigned slot;
        t_letter     gone;
        bit          same;
        hit   = 1'b0;
        start = '0;
        case (op)
            OP_CLEAR: forget_all();
            OP_PATTERN: begin
                if (ltr < ALPHABET) begin
                    // A pattern letter after text starts the text side over.
                    if (text_pos != 0 || win_fill != 0 || ring_ptr != 0) restart_window();
                    if (pat_len < MAX_PATTERN) begin
                        pat_hist[ltr]++;
                        pat_len++;
                    end
                end
            end
            OP_TEXT: begin
                if (ltr < ALPHABET) begin
                    if (pat_len != 0) begin
                        if (win_fill >= pat_len) begin
                            slot = (ring_ptr + MAX_PATTERN - pat_len) % MAX_PATTERN;
                            gone = recent[slot];
                            if (win_hist[gone] != 0) win_hist[gone]--;
                        end else begin
                            win_fill++;
                        end
                        win_hist[ltr]++;
                    end
                    recent[ring_ptr] = ltr;
                    ring_ptr = (ring_ptr == MAX_PATTERN - 1) ? '0 : ring_ptr + 1'b1;
                    text_pos = text_pos + 1;
                    if (pat_len != 0 && win_fill >= pat_len) begin
                        same = 1'b1;
                        for (int i = 0; i < ALPHABET; i++)
                            if (pat_hist[i] != win_hist[i]) same = 1'b0;
                        if (same) begin
                            hit   = 1'b1;
                            start = text_pos - pat_len;
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Drives one beat and returns at the falling edge after it was taken, or after an idle gap at the end of a burst.
    task automatic send_beat(input logic [OPCODE_W-1:0] op, input t_letter ltr,
                             input t_row_check check, input t_index start);
        if (burst_left == 0)
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        item_if.valid  <= 1'b1;
        item_if.opcode <= op;
        item_if.letter <= ltr;
        beat_check     <= check;
        beat_start     <= start;
        do @(posedge i_clk); while (!item_if.ready);
        if (op == OP_CLEAR)
            gen_pattern.delete();
        else if (op == OP_PATTERN && ltr < ALPHABET && gen_pattern.size() < MAX_PATTERN)
            gen_pattern = {gen_pattern, ltr};
        if (!(op == OP_UNUSED || (op != OP_CLEAR && ltr >= ALPHABET))) beats_sent++;
        @(negedge i_clk);
        burst_left--;
        if (burst_left == 0) begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    // Holds the input side until every expected index has come out.
    task automatic settle_results();
        item_if.valid <= 1'b0;
        burst_left = 0;
        while (pending_starts.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    // The receiver cycles through always-ready, random and periodic stall phases.
    always @(negedge i_clk) begin
        stall_tick <= stall_tick + 1'b1;
        case (stall_tick[11:10])
            2'd0:    result_if.ready <= 1'b1;
            2'd1:    result_if.ready <= ($urandom_range(0, 3) != 0);
            2'd2:    result_if.ready <= (stall_tick[4:0] < 5'd20);
            default: result_if.ready <= ($urandom_range(0, 1) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (pending_starts.size() == 0) begin
                $error("start_index: expected none, actual %0d", result_if.start_index);
                mismatches++;
            end else begin
                exp_start = pending_starts.pop_front();
                if (exp_start !== result_if.start_index) begin
                    $error("start_index: expected %0d, actual %0d",
                           exp_start, result_if.start_index);
                    mismatches++;
                end
            end
        end
        if (i_rst_n && item_if.valid && item_if.ready) begin
            anagram_step(item_if.opcode, item_if.letter, step_hit, step_start);
            case (beat_check)
                ROW_NO_HIT: ;
                ROW_HIT:    pending_starts = {pending_starts, beat_start};
                default:    if (step_hit) pending_starts = {pending_starts, step_start};
            endcase
        end
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        t_stim_row  directed_rows [N_DIRECTED];
        t_letter    symbols [4];
        t_letter    perm [$];
        t_letter    swap;
        int         n_sym;
        int         n_pat;
        int         reps;
        int         j;

        i_rst_n          = 1'b0;
        item_if.valid    = 1'b0;
        item_if.opcode   = OP_CLEAR;
        item_if.letter   = '0;
        result_if.ready  = 1'b0;
        beat_check       = ROW_CHECK_MODEL;
        beat_start       = '0;
        stall_tick       = '0;
        mismatches       = 0;
        burst_left       = 0;
        beats_sent       = 0;
        forget_all();

        // Pattern "ab", then "z", then "za"; stray opcodes and out-of-range letters between.
        directed_rows = '{
            '{OP_TEXT,    LTR_A,   ROW_NO_HIT, 32'd0},  // text with an empty pattern
            '{OP_PATTERN, LTR_A,   ROW_NO_HIT, 32'd0},  // restarts the text side
            '{OP_PATTERN, LTR_B,   ROW_NO_HIT, 32'd0},
            '{OP_TEXT,    LTR_B,   ROW_NO_HIT, 32'd0},
            '{OP_TEXT,    LTR_A,   ROW_HIT,    32'd0},
            '{OP_TEXT,    LTR_B,   ROW_HIT,    32'd1},
            '{OP_TEXT,    LTR_MAX, ROW_NO_HIT, 32'd0},
            '{OP_TEXT,    LTR_OUT, ROW_NO_HIT, 32'd0},
            '{OP_UNUSED,  LTR_A,   ROW_NO_HIT, 32'd0},
            '{OP_TEXT,    LTR_A,   ROW_HIT,    32'd2},
            '{OP_TEXT,    LTR_Z,   ROW_NO_HIT, 32'd0},
            '{OP_PATTERN, LTR_MAX, ROW_NO_HIT, 32'd0},  // ignored, so no restart
            '{OP_TEXT,    LTR_A,   ROW_NO_HIT, 32'd0},
            '{OP_CLEAR,   LTR_MAX, ROW_NO_HIT, 32'd0},
            '{OP_TEXT,    LTR_Z,   ROW_NO_HIT, 32'd0},
            '{OP_PATTERN, LTR_Z,   ROW_NO_HIT, 32'd0},
            '{OP_TEXT,    LTR_Z,   ROW_HIT,    32'd0},
            '{OP_TEXT,    LTR_A,   ROW_NO_HIT, 32'd0},
            '{OP_TEXT,    LTR_Z,   ROW_HIT,    32'd2},
            '{OP_PATTERN, LTR_A,   ROW_NO_HIT, 32'd0},
            '{OP_TEXT,    LTR_A,   ROW_NO_HIT, 32'd0},
            '{OP_TEXT,    LTR_A,   ROW_NO_HIT, 32'd0},
            '{OP_TEXT,    LTR_Z,   ROW_HIT,    32'd1},
            '{OP_UNUSED,  LTR_MAX, ROW_NO_HIT, 32'd0},
            '{OP_CLEAR,   LTR_A,   ROW_NO_HIT, 32'd0}
        };

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r])
            send_beat(directed_rows[r].op, directed_rows[r].ltr,
                      directed_rows[r].check, directed_rows[r].start);
        settle_results();

        // Random part: mostly a pattern over a few letters followed by shuffles of it,
        // so windows line up with permutations often; the rest is raw noise.
        while (beats_sent < N_DIRECTED + N_RANDOM) begin
            if ($urandom_range(0, 99) < 15) begin
                repeat ($urandom_range(1, 8))
                    send_beat(OPCODE_W'($urandom_range(0, 3)),
                              LETTER_W'($urandom_range(0, 31)), ROW_CHECK_MODEL, '0);
            end else begin
                n_sym = $urandom_range(1, 4);
                for (int i = 0; i < n_sym; i++)
                    symbols[i] = LETTER_W'($urandom_range(0, ALPHABET - 1));
                if ($urandom_range(0, 3) == 0)
                    send_beat(OP_CLEAR, LETTER_W'($urandom_range(0, 31)), ROW_CHECK_MODEL, '0);
                // Now and then a pattern near or past the maximum length.
                n_pat = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 70)
                                                     : $urandom_range(1, 6);
                repeat (n_pat)
                    send_beat(OP_PATTERN, symbols[$urandom_range(0, n_sym - 1)],
                              ROW_CHECK_MODEL, '0);
                reps = (gen_pattern.size() > 16) ? $urandom_range(1, 3) : $urandom_range(2, 8);
                repeat (reps) begin
                    perm = gen_pattern;
                    for (int i = perm.size() - 1; i > 0; i--) begin
                        j       = $urandom_range(0, i);
                        swap    = perm[i];
                        perm[i] = perm[j];
                        perm[j] = swap;
                    end
                    foreach (perm[k]) begin
                        if ($urandom_range(0, 19) == 0)
                            send_beat(OP_TEXT, LETTER_W'($urandom_range(0, 31)),
                                      ROW_CHECK_MODEL, '0);
                        send_beat(OP_TEXT, perm[k], ROW_CHECK_MODEL, '0);
                    end
                end
            end
            if ($urandom_range(0, 9) == 0) settle_results();
        end

        settle_results();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
